>>> hdl/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types and constants of the retransmit timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package rtt_pkg;

  localparam int TABLE_DEPTH    = 16;
  localparam int IDX_W          = $clog2(TABLE_DEPTH);
  localparam int KEY_W          = 64;
  localparam int CFG_W          = 12;
  localparam int RETRY_W        = 8;
  localparam int EV_W           = 3;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int ADDR_W         = 4;
  localparam int DATA_W         = 32;

  localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

  localparam logic [CFG_W-1:0] MIN_INTERVAL_RST    = CFG_W'(5);
  localparam logic [CFG_W-1:0] DELAY_INCREMENT_RST = CFG_W'(5);
  localparam logic [CFG_W-1:0] MAX_LIFETIME_RST    = CFG_W'(20);

  typedef enum logic [1:0] {
    REG_MIN_INTERVAL    = 2'd0,
    REG_DELAY_INCREMENT = 2'd1,
    REG_MAX_LIFETIME    = 2'd2,
    REG_UNUSED          = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_ACK    = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_IGNORE = 2'd3
  } req_t;

  typedef enum logic [EV_W-1:0] {
    EV_ADDED     = 3'd0,
    EV_REPLACED  = 3'd1,
    EV_FULL      = 3'd2,
    EV_ACK_HIT   = 3'd3,
    EV_ACK_MISS  = 3'd4,
    EV_RESEND    = 3'd5,
    EV_GIVE_UP   = 3'd6,
    EV_SCAN_DONE = 3'd7
  } ev_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_ADD,
    WR_CLEAR,
    WR_RESEND
  } wr_op_t;

  typedef struct packed {
    wr_op_t             op;
    logic [IDX_W-1:0]   idx;
    logic [KEY_W-1:0]   key;
    logic [RETRY_W-1:0] retries;
  } wr_cmd_t;

  typedef struct packed {
    logic               match;
    logic               expired;
    logic               due;
    logic [RETRY_W-1:0] retry_next;
  } eval_t;

endpackage

`default_nettype wire

>>> hdl/rtt_eval.sv
// ----------------------------------------------------------------------------
// rtt_eval
// Shared entry evaluator: key compare, age and backoff checks, retry bump.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_eval
  import rtt_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic [KEY_W-1:0]      key,
  input  wire logic [KEY_W-1:0]      entry_key,
  input  wire logic [TIME_WIDTH-1:0] now,
  input  wire logic [TIME_WIDTH-1:0] first_time,
  input  wire logic [TIME_WIDTH-1:0] last_time,
  input  wire logic [RETRY_W-1:0]    retries,
  input  wire logic [CFG_W-1:0]      min_interval,
  input  wire logic [CFG_W-1:0]      delay_increment,
  input  wire logic [CFG_W-1:0]      max_lifetime,
  output eval_t                      result
);

  localparam int DLY_W = CFG_W + RETRY_W + 1;
  localparam int CMP_W = (TIME_WIDTH > DLY_W) ? TIME_WIDTH : DLY_W;
  localparam int BO_W  = CFG_W + RETRY_W;

  logic [TIME_WIDTH-1:0]    age;
  logic [TIME_WIDTH-1:0]    idle;
  logic [CFG_W-1:0]         eff_min;
  logic [CFG_W+RETRY_W-1:0] backoff;
  logic [DLY_W-1:0]         delay;

  always_comb begin
    age     = now - first_time;
    idle    = now - last_time;
    eff_min = (min_interval > max_lifetime) ? max_lifetime : min_interval;
    backoff = BO_W'(delay_increment) * BO_W'(retries);
    delay   = DLY_W'(eff_min) + DLY_W'(backoff);

    result.match      = (entry_key == key);
    result.expired    = CMP_W'(age) > CMP_W'(max_lifetime);
    result.due        = CMP_W'(idle) >= CMP_W'(delay);
    result.retry_next = (retries == RETRY_MAX) ? RETRY_MAX : retries + 1'b1;
  end

endmodule

`default_nettype wire

>>> hdl/rtt_store.sv
// ----------------------------------------------------------------------------
// rtt_store
// Entry storage: valid bits, keys, send stamps and retry counts.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_store
  import rtt_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire wr_cmd_t               wr,
  input  wire logic [TIME_WIDTH-1:0] now,
  input  wire logic [IDX_W-1:0]      rd_idx,
  output logic                       rd_valid,
  output logic [KEY_W-1:0]           rd_key,
  output logic [TIME_WIDTH-1:0]      rd_first,
  output logic [TIME_WIDTH-1:0]      rd_last,
  output logic [RETRY_W-1:0]         rd_retries
);

  logic [TABLE_DEPTH-1:0] valid;
  logic [KEY_W-1:0]       key_arr   [TABLE_DEPTH];
  logic [TIME_WIDTH-1:0]  first_arr [TABLE_DEPTH];
  logic [TIME_WIDTH-1:0]  last_arr  [TABLE_DEPTH];
  logic [RETRY_W-1:0]     retry_arr [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (wr.op == WR_ADD) begin
        valid[wr.idx] <= 1'b1;
      end else if (wr.op == WR_CLEAR) begin
        valid[wr.idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.op == WR_ADD) begin
      key_arr[wr.idx]   <= wr.key;
      first_arr[wr.idx] <= now;
      last_arr[wr.idx]  <= now;
      retry_arr[wr.idx] <= '0;
    end else if (wr.op == WR_RESEND) begin
      last_arr[wr.idx]  <= now;
      retry_arr[wr.idx] <= wr.retries;
    end
  end

  assign rd_valid   = valid[rd_idx];
  assign rd_key     = key_arr[rd_idx];
  assign rd_first   = first_arr[rd_idx];
  assign rd_last    = last_arr[rd_idx];
  assign rd_retries = retry_arr[rd_idx];

endmodule

`default_nettype wire

>>> hdl/retransmit_timer_table.sv
// ----------------------------------------------------------------------------
// retransmit_timer_table
// Table of outstanding messages with linear resend backoff and give-up aging.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. req_type
//   selects add (seq_key stored), acknowledgement (seq_key removed) or tick
//   (time advances by one, every entry is checked). Type 3 is dropped.
//   Each result is shown for one cycle with done high; last marks the final
//   result of a transaction. The receiver cannot stall; results are never
//   held back.
//   Timing: one entry per cycle passes through the shared evaluator. Add,
//   tick and a missed acknowledgement walk all 16 slots and give their
//   final result from the finish state; busy falls in the cycle that shows
//   it. A matching acknowledgement ends at its slot. Tick results come out
//   as their slots are passed. Registers are to be written over the APB
//   port only while the block is idle; the block does not enforce this.
//   Reset clears all entries, the time counter and the registers to their
//   defaults; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module retransmit_timer_table
  import rtt_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        req_type,
  input  wire logic [KEY_W-1:0]  seq_key,
  output logic                   done,
  output logic [EV_W-1:0]        event_res,
  output logic [KEY_W-1:0]       key_out,
  output logic [IDX_W-1:0]       slot,
  output logic [RETRY_W-1:0]     retry_number,
  output logic                   last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [CFG_W-1:0] min_interval;
  logic [CFG_W-1:0] delay_increment;
  logic [CFG_W-1:0] max_lifetime;
  reg_idx_t         reg_sel;
  logic             reg_wr;

  state_t                state, state_next;
  logic [IDX_W-1:0]      idx, idx_next;
  req_t                  req_q;
  logic [KEY_W-1:0]      key_q;
  logic [TIME_WIDTH-1:0] now;
  logic                  hit_found, hit_found_next;
  logic [IDX_W-1:0]      hit_idx, hit_idx_next;
  logic                  free_found, free_found_next;
  logic [IDX_W-1:0]      free_idx, free_idx_next;
  logic                  accept;

  logic                  done_next;
  ev_t                   ev_next;
  logic [KEY_W-1:0]      key_out_next;
  logic [IDX_W-1:0]      slot_next;
  logic [RETRY_W-1:0]    retry_number_next;
  logic                  last_next;

  wr_cmd_t               wr;
  logic                  e_valid;
  logic [KEY_W-1:0]      e_key;
  logic [TIME_WIDTH-1:0] e_first;
  logic [TIME_WIDTH-1:0] e_last;
  logic [RETRY_W-1:0]    e_retries;
  eval_t                 ev;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval    <= MIN_INTERVAL_RST;
      delay_increment <= DELAY_INCREMENT_RST;
      max_lifetime    <= MAX_LIFETIME_RST;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_MIN_INTERVAL:    min_interval    <= pwdata[CFG_W-1:0];
        REG_DELAY_INCREMENT: delay_increment <= pwdata[CFG_W-1:0];
        REG_MAX_LIFETIME:    max_lifetime    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_INTERVAL:    prdata = DATA_W'(min_interval);
      REG_DELAY_INCREMENT: prdata = DATA_W'(delay_increment);
      REG_MAX_LIFETIME:    prdata = DATA_W'(max_lifetime);
      default:             prdata = '0;
    endcase
  end

  // storage and shared evaluator
  rtt_store #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .now        (now),
    .rd_idx     (idx),
    .rd_valid   (e_valid),
    .rd_key     (e_key),
    .rd_first   (e_first),
    .rd_last    (e_last),
    .rd_retries (e_retries)
  );

  rtt_eval #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_eval (
    .key             (key_q),
    .entry_key       (e_key),
    .now             (now),
    .first_time      (e_first),
    .last_time       (e_last),
    .retries         (e_retries),
    .min_interval    (min_interval),
    .delay_increment (delay_increment),
    .max_lifetime    (max_lifetime),
    .result          (ev)
  );

  // sequencer
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      now        <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      hit_found  <= hit_found_next;
      free_found <= free_found_next;
      done       <= done_next;
      if (accept && req_t'(req_type) == REQ_TICK) begin
        now <= now + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_idx      <= hit_idx_next;
    free_idx     <= free_idx_next;
    event_res    <= ev_next;
    key_out      <= key_out_next;
    slot         <= slot_next;
    retry_number <= retry_number_next;
    last         <= last_next;
    if (accept) begin
      req_q <= req_t'(req_type);
      key_q <= seq_key;
    end
  end

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    hit_found_next    = hit_found;
    hit_idx_next      = hit_idx;
    free_found_next   = free_found;
    free_idx_next     = free_idx;
    wr.op             = WR_NONE;
    wr.idx            = idx;
    wr.key            = key_q;
    wr.retries        = ev.retry_next;
    done_next         = 1'b0;
    ev_next           = EV_SCAN_DONE;
    key_out_next      = '0;
    slot_next         = '0;
    retry_number_next = '0;
    last_next         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept && req_t'(req_type) != REQ_IGNORE) begin
          state_next      = ST_SCAN;
          idx_next        = '0;
          hit_found_next  = 1'b0;
          free_found_next = 1'b0;
        end
      end

      ST_SCAN: begin
        idx_next = idx + 1'b1;
        if (idx == IDX_LAST) begin
          state_next = ST_FINISH;
          idx_next   = '0;
        end
        unique case (req_q)
          REQ_ADD: begin
            if (e_valid && ev.match && !hit_found) begin
              hit_found_next = 1'b1;
              hit_idx_next   = idx;
            end
            if (!e_valid && !free_found) begin
              free_found_next = 1'b1;
              free_idx_next   = idx;
            end
          end
          REQ_ACK: begin
            if (e_valid && ev.match) begin
              wr.op        = WR_CLEAR;
              done_next    = 1'b1;
              ev_next      = EV_ACK_HIT;
              key_out_next = key_q;
              slot_next    = idx;
              last_next    = 1'b1;
              state_next   = ST_IDLE;
              idx_next     = '0;
            end
          end
          REQ_TICK: begin
            if (e_valid && ev.expired) begin
              wr.op        = WR_CLEAR;
              done_next    = 1'b1;
              ev_next      = EV_GIVE_UP;
              key_out_next = e_key;
              slot_next    = idx;
            end else if (e_valid && ev.due) begin
              wr.op             = WR_RESEND;
              done_next         = 1'b1;
              ev_next           = EV_RESEND;
              key_out_next      = e_key;
              slot_next         = idx;
              retry_number_next = ev.retry_next;
            end
          end
          default: begin
            state_next = ST_IDLE;
            idx_next   = '0;
          end
        endcase
      end

      ST_FINISH: begin
        state_next = ST_IDLE;
        done_next  = 1'b1;
        last_next  = 1'b1;
        unique case (req_q)
          REQ_ADD: begin
            key_out_next = key_q;
            if (hit_found) begin
              wr.op     = WR_ADD;
              wr.idx    = hit_idx;
              ev_next   = EV_REPLACED;
              slot_next = hit_idx;
            end else if (free_found) begin
              wr.op     = WR_ADD;
              wr.idx    = free_idx;
              ev_next   = EV_ADDED;
              slot_next = free_idx;
            end else begin
              ev_next = EV_FULL;
            end
          end
          REQ_ACK: begin
            ev_next      = EV_ACK_MISS;
            key_out_next = key_q;
          end
          REQ_TICK: begin
            ev_next = EV_SCAN_DONE;
          end
          default: begin
            done_next = 1'b0;
            last_next = 1'b0;
          end
        endcase
      end

      default: begin
        state_next = ST_IDLE;
        idx_next   = '0;
      end
    endcase
  end

  // checks
  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != ST_IDLE)
    else $error("result without a transaction in progress");

  a_last_ends_work: assert property (@(posedge clk) disable iff (rst)
    (done && last) |-> state == ST_IDLE)
    else $error("final result while sequencer still busy");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_TICK) |=> now == TIME_WIDTH'($past(now) + 1'b1))
    else $error("time counter did not advance on tick");

  a_idle_idx_zero: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> idx == '0)
    else $error("scan index not parked while idle");

endmodule

`default_nettype wire
